// ----- hdl/assert_macros.svh -----
// assertion macros included by the scanline fill query core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous reset disable
`define SFQ_ASSERT(label, clk_s, rst_n_s, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// implication checked in the cycle after the antecedent
`define SFQ_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sfq_pkg.sv -----
// types and constants of the scanline fill query block
package sfq_pkg;

	localparam int XW        = 32;
	localparam int DIR_W     = 2;
	localparam int CNT_OUT_W = 7;
	localparam int SUM_OUT_W = 8;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RULE_NONZERO  = 2'd0,
		RULE_ODD      = 2'd1,
		RULE_POSITIVE = 2'd2,
		RULE_NEGATIVE = 2'd3
	} rule_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_RESULT
	} state_t;

endpackage

// ----- hdl/sfq_req_if.sv -----
// command channel interface
interface sfq_req_if import sfq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              command;
	logic signed [XW-1:0]    x_pos;
	logic signed [DIR_W-1:0] direction;
	logic [1:0]              fill_rule;

	modport source (output valid, command, x_pos, direction, fill_rule, input ready);
	modport sink (input valid, command, x_pos, direction, fill_rule, output ready);
endinterface

// ----- hdl/sfq_rsp_if.sv -----
// query result channel interface
interface sfq_rsp_if import sfq_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic                        filled;
	logic [CNT_OUT_W-1:0]        crossing_count;
	logic signed [SUM_OUT_W-1:0] winding_sum;
	logic                        overflow;

	modport source (output valid, filled, crossing_count, winding_sum, overflow, input ready);
	modport sink (input valid, filled, crossing_count, winding_sum, overflow, output ready);
endinterface

// ----- hdl/scanline_fill_query_core.sv -----
// sorted crossing table in one memory with a fill rule query
//
//  channel | dir | payload
//  req     | in  | command, x_pos, direction, fill_rule
//  rsp     | out | filled, crossing_count, winding_sum, overflow
//
// clear, a dropped add and an unused command finish in the idle state; a query
// scans the crossings at or left of x, stopping on the first larger entry or at
// the table's end, then waits in the result state until an earlier result is taken.
// an add scans the same way, then moves the entries right of its place up one
// slot through the single read and write port, reading and writing each in turn,
// and then writes the new entry.
// arst_n clears the count, the overflow flag and the control; the memory is
// not cleared, entries beyond the count are never read.
// a waiting result holds back new commands only once a later query has its result.
module scanline_fill_query_core import sfq_pkg::*; #(
	parameter int MAX_CROSSINGS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	sfq_req_if.sink   req,
	sfq_rsp_if.source rsp
);
	`include "assert_macros.svh"

	localparam int IW = $clog2(MAX_CROSSINGS);
	localparam int CW = $clog2(MAX_CROSSINGS + 1);
	localparam int WW = $clog2(MAX_CROSSINGS) + 2;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_CROSSINGS);
	localparam logic signed [WW-1:0] DIR_NEG = '1;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [WW-1:0] w;
	} entry_t;

	// crossing memory
	entry_t mem [MAX_CROSSINGS];
	entry_t rd_s1;
	logic rd_en, wr_en;
	logic [IW-1:0] rd_addr, wr_addr;
	entry_t wr_data;

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic signed [XW-1:0] x_q;
	logic signed [WW-1:0] dir_q, sum_q;
	logic [1:0] rule_q;
	logic [CW-1:0] cnt_q, idx_q, ptr_q, ptr_m1;
	logic ovf_q;
	logic out_valid_q, filled_q, ovf_out_q;
	logic [CNT_OUT_W-1:0] count_out_q;
	logic signed [SUM_OUT_W-1:0] sum_out_q;

	logic acc, scan_more, scan_hit, shift_more, out_free, rule_hit;

	assign acc        = req.valid & req.ready;
	assign scan_more  = idx_q < cnt_q;
	assign scan_hit   = rd_s1.x <= x_q;
	assign shift_more = ptr_q > idx_q;
	assign out_free   = !out_valid_q || rsp.ready;
	assign ptr_m1     = ptr_q - CW'(1);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_s1 <= mem[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (req.command == CMD_QUERY) state_d = ST_SCAN_RD;
					else if (req.command == CMD_ADD && cnt_q < CNT_MAX) state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				if (scan_more) state_d = ST_SCAN_CHK;
				else state_d = (cmd_q == CMD_QUERY) ? ST_RESULT : ST_SHIFT_RD;
			end
			ST_SCAN_CHK: begin
				if (scan_hit) state_d = ST_SCAN_RD;
				else state_d = (cmd_q == CMD_QUERY) ? ST_RESULT : ST_SHIFT_RD;
			end
			ST_SHIFT_RD: state_d = shift_more ? ST_SHIFT_WR : ST_IDLE;
			ST_SHIFT_WR: state_d = ST_SHIFT_RD;
			ST_RESULT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port and handshake controls
	always_comb begin
		req.ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = idx_q[IW-1:0];
		wr_en     = 1'b0;
		wr_addr   = idx_q[IW-1:0];
		wr_data   = '{x: x_q, w: sum_q + dir_q};
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SCAN_RD: rd_en = scan_more;
			ST_SHIFT_RD: begin
				rd_en   = shift_more;
				rd_addr = ptr_m1[IW-1:0];
				wr_en   = !shift_more;
			end
			ST_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[IW-1:0];
				wr_data = '{x: rd_s1.x, w: rd_s1.w + dir_q};
			end
			default: ;
		endcase
	end

	// fill rule on the exact sum
	always_comb begin
		case (rule_t'(rule_q))
			RULE_NONZERO:  rule_hit = sum_q != '0;
			RULE_ODD:      rule_hit = sum_q[0];
			RULE_POSITIVE: rule_hit = sum_q > 0;
			default:       rule_hit = sum_q < 0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc && req.command == CMD_CLEAR) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			if (acc && req.command == CMD_ADD && cnt_q >= CNT_MAX) ovf_q <= 1'b1;
			if (state_q == ST_SHIFT_RD && !shift_more) cnt_q <= cnt_q + CW'(1);
			if (state_q == ST_RESULT && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q  <= cmd_t'(req.command);
			x_q    <= req.x_pos;
			rule_q <= req.fill_rule;
			dir_q  <= (req.direction == 2'sb10) ? DIR_NEG : WW'(req.direction);
			idx_q  <= '0;
			sum_q  <= '0;
			ptr_q  <= cnt_q;
		end
		if (state_q == ST_SCAN_CHK && scan_hit) begin
			idx_q <= idx_q + CW'(1);
			sum_q <= rd_s1.w;
		end
		if (state_q == ST_SHIFT_WR) ptr_q <= ptr_m1;
		if (state_q == ST_RESULT && out_free) begin
			filled_q    <= rule_hit;
			count_out_q <= CNT_OUT_W'(idx_q);
			sum_out_q   <= SUM_OUT_W'(sum_q);
			ovf_out_q   <= ovf_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.filled         = filled_q;
	assign rsp.crossing_count = count_out_q;
	assign rsp.winding_sum    = sum_out_q;
	assign rsp.overflow       = ovf_out_q;

	// checks
	`SFQ_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CNT_MAX, "entry count above capacity")
	`SFQ_ASSERT(a_shift_order, clk, arst_n, (state_q == ST_SHIFT_WR) |-> (ptr_q > idx_q),
		"shift write at or below insert slot")
	`SFQ_ASSERT_NEXT(a_clear, clk, arst_n, acc && req.command == CMD_CLEAR,
		cnt_q == '0 && !ovf_q, "clear did not empty table")
	`SFQ_ASSERT(a_scan_bound, clk, arst_n, (state_q == ST_SCAN_CHK) |-> (idx_q < cnt_q),
		"scan read beyond valid entries")
endmodule

// ----- tb/scanline_fill_query_core_tb.sv -----
// self-checking testbench of the scanline fill query core
`timescale 1ns / 1ps

module scanline_fill_query_core_tb;
	import sfq_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int RANDOM_ITEMS = 1950;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		cmd_t                    cmd;
		logic signed [XW-1:0]    x;
		logic [DIR_W-1:0]        dir;
		rule_t                   rule;
	} crossing_cmd_t;

	typedef struct {
		logic                        filled;
		logic [CNT_OUT_W-1:0]        count;
		logic signed [SUM_OUT_W-1:0] sum;
		logic                        ovf;
	} fill_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sfq_req_if req_ch ();
	sfq_rsp_if rsp_ch ();

	scanline_fill_query_core #(.MAX_CROSSINGS(TABLE_DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	crossing_cmd_t pending_cmds[$];
	fill_answer_t  answers_due[$];
	int            mismatches = 0;
	bit            no_idle = 1'b0;

	// shadow of the crossing table
	logic signed [XW-1:0] shadow_x[TABLE_DEPTH];
	int                   shadow_wind[TABLE_DEPTH];
	int                   shadow_cnt = 0;
	bit                   shadow_ovf = 1'b0;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int crossings_left_of(logic signed [XW-1:0] x);
		int n;
		n = 0;
		while (n < shadow_cnt && shadow_x[n] <= x)
			n++;
		return n;
	endfunction

	// update the shadow table for one accepted transaction, queueing a query's answer
	function automatic void apply_crossing_cmd(crossing_cmd_t c);
		int n;
		int d;
		int wsum;
		int base;
		fill_answer_t a;
		case (c.cmd)
			CMD_CLEAR: begin
				shadow_cnt = 0;
				shadow_ovf = 1'b0;
			end
			CMD_ADD: begin
				d = $signed(c.dir);
				if (d < -1)
					d = -1;
				if (shadow_cnt >= TABLE_DEPTH) begin
					shadow_ovf = 1'b1;
				end else begin
					n = crossings_left_of(c.x);
					base = (n > 0) ? shadow_wind[n-1] : 0;
					for (int i = shadow_cnt; i > n; i--) begin
						shadow_x[i] = shadow_x[i-1];
						shadow_wind[i] = shadow_wind[i-1] + d;
					end
					shadow_x[n] = c.x;
					shadow_wind[n] = base + d;
					shadow_cnt++;
				end
			end
			CMD_QUERY: begin
				n = crossings_left_of(c.x);
				wsum = (n > 0) ? shadow_wind[n-1] : 0;
				case (c.rule)
					RULE_NONZERO:  a.filled = (wsum != 0);
					RULE_ODD:      a.filled = wsum[0];
					RULE_POSITIVE: a.filled = (wsum > 0);
					default:       a.filled = (wsum < 0);
				endcase
				a.count = n[CNT_OUT_W-1:0];
				a.sum = wsum[SUM_OUT_W-1:0];
				a.ovf = shadow_ovf;
				answers_due.push_back(a);
			end
			default: ;
		endcase
	endfunction

	// command driver with idle bursts
	int req_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && !req_ch.ready) begin
				// hold the transaction
			end else begin
				if (req_ch.valid)
					apply_crossing_cmd('{cmd_t'(req_ch.command), req_ch.x_pos,
						req_ch.direction, rule_t'(req_ch.fill_rule)});
				if (req_gap > 0) begin
					req_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_cmds.size() > 0 && !no_idle
						&& $urandom_range(0, 11) == 0) begin
					req_gap = $urandom_range(1, 15) - 1;
					req_ch.valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					crossing_cmd_t c;
					c = pending_cmds.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.command <= c.cmd;
					req_ch.x_pos <= c.x;
					req_ch.direction <= c.dir;
					req_ch.fill_rule <= c.rule;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with stall bursts
	int rsp_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (answers_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: filled %0d count %0d sum %0d ovf %0d",
							rsp_ch.filled, rsp_ch.crossing_count,
							rsp_ch.winding_sum, rsp_ch.overflow);
				end else begin
					fill_answer_t a;
					a = answers_due.pop_front();
					if (rsp_ch.filled !== a.filled || rsp_ch.crossing_count !== a.count
							|| rsp_ch.winding_sum !== a.sum
							|| rsp_ch.overflow !== a.ovf) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected filled %0d count %0d sum %0d ovf %0d, got filled %0d count %0d sum %0d ovf %0d",
								a.filled, a.count, a.sum, a.ovf, rsp_ch.filled,
								rsp_ch.crossing_count, rsp_ch.winding_sum,
								rsp_ch.overflow);
					end
				end
			end
			if (rsp_gap > 0) begin
				rsp_gap--;
				rsp_ch.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				rsp_gap = $urandom_range(1, 15) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	function automatic void push_cmd(cmd_t c, logic signed [XW-1:0] x,
			logic [DIR_W-1:0] d, rule_t r);
		pending_cmds.push_back('{c, x, d, r});
	endfunction

	// x values biased toward collisions and the range ends
	function automatic logic signed [XW-1:0] pick_x();
		int k;
		k = $urandom_range(0, 9);
		if (k < 3)
			return $urandom;
		else if (k == 3)
			return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
		else
			return ($signed($urandom_range(0, 24)) - 12) <<< 15;
	endfunction

	// stimulus
	initial begin
		int issued;
		int adds;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_CLEAR;
		req_ch.x_pos = '0;
		req_ch.direction = '0;
		req_ch.fill_rule = RULE_NONZERO;
		rsp_ch.ready = 1'b0;

		// directed: range ends, every rule, equal x, direction pattern -2, unused command
		push_cmd(CMD_CLEAR, 0, 2'b00, RULE_NONZERO);
		push_cmd(CMD_QUERY, 0, 2'b11, RULE_NONZERO);
		push_cmd(CMD_ADD, 32'sh80000000, 2'b01, RULE_NONZERO);
		push_cmd(CMD_ADD, 32'sh7fffffff, 2'b11, RULE_ODD);
		push_cmd(CMD_ADD, 0, 2'b00, RULE_POSITIVE);
		push_cmd(CMD_ADD, 0, 2'b10, RULE_NEGATIVE);
		push_cmd(CMD_ADD, 0, 2'b01, RULE_NONZERO);
		push_cmd(CMD_ADD, 0, 2'b10, RULE_NONZERO);
		push_cmd(CMD_QUERY, 32'sh80000000, 2'b00, RULE_NONZERO);
		push_cmd(CMD_QUERY, -1, 2'b00, RULE_ODD);
		push_cmd(CMD_QUERY, 0, 2'b00, RULE_POSITIVE);
		push_cmd(CMD_QUERY, 0, 2'b00, RULE_NEGATIVE);
		push_cmd(CMD_QUERY, 0, 2'b00, RULE_ODD);
		push_cmd(CMD_NOP, 32'sh5a5a5a5a, 2'b01, RULE_ODD);
		push_cmd(CMD_QUERY, 32'sh7ffffffe, 2'b00, RULE_NONZERO);
		push_cmd(CMD_QUERY, 32'sh7fffffff, 2'b00, RULE_NEGATIVE);
		push_cmd(CMD_CLEAR, -1, 2'b11, RULE_NEGATIVE);
		push_cmd(CMD_QUERY, 32'sh7fffffff, 2'b00, RULE_NONZERO);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// hold off until the directed part has fully drained
		@(posedge clk);
		while (pending_cmds.size() > 0 || answers_due.size() > 0 || req_ch.valid)
			@(posedge clk);

		// random: usually a clear, a run of adds (sometimes past full), then queries
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) != 0) begin
				push_cmd(CMD_CLEAR, $urandom, 2'($urandom), rule_t'($urandom));
				issued++;
			end
			case ($urandom_range(0, 9))
				0:       adds = $urandom_range(60, 70);
				1:       adds = $urandom_range(20, 40);
				default: adds = $urandom_range(0, 10);
			endcase
			for (int i = 0; i < adds; i++) begin
				push_cmd(CMD_ADD, pick_x(), 2'($urandom), rule_t'($urandom));
				issued++;
				if ($urandom_range(0, 15) == 0) begin
					push_cmd(CMD_QUERY, pick_x(), 2'($urandom), rule_t'($urandom));
					issued++;
				end
			end
			for (int i = $urandom_range(1, 8); i > 0; i--) begin
				if ($urandom_range(0, 19) == 0) begin
					push_cmd(CMD_NOP, $urandom, 2'($urandom), rule_t'($urandom));
				end else begin
					push_cmd(CMD_QUERY, pick_x(), 2'($urandom), rule_t'($urandom));
					issued++;
				end
			end
		end

		// quiet tail with no idling
		while (pending_cmds.size() > 150)
			@(posedge clk);
		no_idle = 1'b1;
		while (pending_cmds.size() > 0 || answers_due.size() > 0 || req_ch.valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && answers_due.size() == 0)
			$display("scanline_fill_query_core test passed");
		else
			$display("scanline_fill_query_core test failed");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("scanline_fill_query_core test failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/sfq_pkg.sv
hdl/sfq_req_if.sv
hdl/sfq_rsp_if.sv
hdl/scanline_fill_query_core.sv
tb/scanline_fill_query_core_tb.sv
